>>> src/cfp_pkg.sv
package cfp_pkg;

    localparam int COORD_W  = 16;
    localparam int TAG_W    = 16;
    localparam int CFG_W    = 16;
    localparam int OUT_W    = 24;
    localparam int STATUS_W = 2;

    // divider: numerator 2|n|+|det|, divisor 4|det|, quotient kept to 27 bits
    localparam int NUM_W = 52;
    localparam int DEN_W = 36;
    localparam int Q_W   = 27;

    // square root of dx^2+dy^2, each magnitude below 2^24
    localparam int SQ_W   = 49;
    localparam int ROOT_W = 25;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_COLL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SAT  = 2'd2;

    localparam logic signed [OUT_W-1:0] CTR_MAX = 24'sh7FFFFF;
    localparam logic signed [OUT_W-1:0] CTR_MIN = 24'sh800000;
    localparam logic [OUT_W-1:0]        RAD_MAX = 24'hFFFFFF;

    typedef struct packed {
        logic                      valid;
        logic [TAG_W-1:0]          tag;
        logic                      coll;
        logic signed [COORD_W-1:0] x2;
        logic signed [COORD_W-1:0] y2;
    } cfp_side_t;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
        logic             neg;
    } cfp_lane_t;

    typedef struct packed {
        logic             valid;
        logic [TAG_W-1:0] tag;
        logic             coll;
        logic             sat;
        logic             rad_ovf;
        logic [OUT_W-1:0] cx;
        logic [OUT_W-1:0] cy;
    } cfp_post_t;

endpackage

>>> src/cfp_front.sv
module cfp_front
    import cfp_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic signed [COORD_W-1:0] x1,
    input  logic signed [COORD_W-1:0] y1,
    input  logic signed [COORD_W-1:0] x2,
    input  logic signed [COORD_W-1:0] y2,
    input  logic signed [COORD_W-1:0] x3,
    input  logic signed [COORD_W-1:0] y3,
    input  logic [TAG_W-1:0]          tag,
    input  logic [CFG_W-1:0]          min_abs_det,
    output cfp_side_t                 side_out,
    output cfp_lane_t [1:0]           lanes_out
);

    logic [4:0] vld_reg;
    logic [TAG_W-1:0] tag_reg [5];
    logic signed [COORD_W-1:0] x2_reg [5];
    logic signed [COORD_W-1:0] y2_reg [5];

    // stage 1: differences and squares
    logic signed [16:0] dx12_reg, dx23_reg, dy12_reg, dy23_reg;
    logic signed [31:0] sqx1_reg, sqy1_reg, sqx2_reg, sqy2_reg, sqx3_reg, sqy3_reg;
    // stage 2
    logic signed [32:0] bc2_reg, cd2_reg;
    logic signed [33:0] p1_reg, p2_reg;
    logic signed [16:0] dx12b_reg, dx23b_reg, dy12b_reg, dy23b_reg;
    // stage 3
    logic signed [34:0] det_reg;
    logic signed [49:0] pa_reg, pb_reg, pc_reg, pd_reg;
    // stage 4
    logic signed [50:0] nx_reg, ny_reg;
    logic [33:0]        adet_reg;
    logic               dneg_reg;
    logic               coll_reg;
    // stage 5
    cfp_lane_t [1:0]    lane_reg;
    logic               coll5_reg;

    logic [31:0] s1, s2, s3;
    logic signed [34:0] det_c;
    logic [33:0] adet_c;
    logic [49:0] anx, any;

    always_comb
    begin
        s1 = sqx1_reg + sqy1_reg;
        s2 = sqx2_reg + sqy2_reg;
        s3 = sqx3_reg + sqy3_reg;
        det_c = det_reg;
        adet_c = det_c[34] ? 34'(-det_c) : det_c[33:0];
        anx = nx_reg[50] ? 50'(-nx_reg) : nx_reg[49:0];
        any = ny_reg[50] ? 50'(-ny_reg) : ny_reg[49:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tag_reg[0] <= tag;
            x2_reg[0]  <= x2;
            y2_reg[0]  <= y2;
            for (int i = 1; i < 5; i++)
            begin
                tag_reg[i] <= tag_reg[i-1];
                x2_reg[i]  <= x2_reg[i-1];
                y2_reg[i]  <= y2_reg[i-1];
            end

            dx12_reg <= {x1[15], x1} - {x2[15], x2};
            dx23_reg <= {x2[15], x2} - {x3[15], x3};
            dy12_reg <= {y1[15], y1} - {y2[15], y2};
            dy23_reg <= {y2[15], y2} - {y3[15], y3};
            sqx1_reg <= x1 * x1;
            sqy1_reg <= y1 * y1;
            sqx2_reg <= x2 * x2;
            sqy2_reg <= y2 * y2;
            sqx3_reg <= x3 * x3;
            sqy3_reg <= y3 * y3;

            bc2_reg   <= {1'b0, s1} - {1'b0, s2};
            cd2_reg   <= {1'b0, s2} - {1'b0, s3};
            p1_reg    <= dx12_reg * dy23_reg;
            p2_reg    <= dx23_reg * dy12_reg;
            dx12b_reg <= dx12_reg;
            dx23b_reg <= dx23_reg;
            dy12b_reg <= dy12_reg;
            dy23b_reg <= dy23_reg;

            det_reg <= {p1_reg[33], p1_reg} - {p2_reg[33], p2_reg};
            pa_reg  <= bc2_reg * dy23b_reg;
            pb_reg  <= cd2_reg * dy12b_reg;
            pc_reg  <= cd2_reg * dx12b_reg;
            pd_reg  <= bc2_reg * dx23b_reg;

            nx_reg   <= {pa_reg[49], pa_reg} - {pb_reg[49], pb_reg};
            ny_reg   <= {pc_reg[49], pc_reg} - {pd_reg[49], pd_reg};
            adet_reg <= adet_c;
            dneg_reg <= det_reg[34];
            coll_reg <= (adet_c == '0) || (adet_c < {18'd0, min_abs_det});

            lane_reg[0].num <= {1'b0, anx, 1'b0} + {18'd0, adet_reg};
            lane_reg[0].den <= {adet_reg, 2'b00};
            lane_reg[0].neg <= nx_reg[50] ^ dneg_reg;
            lane_reg[1].num <= {1'b0, any, 1'b0} + {18'd0, adet_reg};
            lane_reg[1].den <= {adet_reg, 2'b00};
            lane_reg[1].neg <= ny_reg[50] ^ dneg_reg;
            coll5_reg <= coll_reg;
        end
    end

    assign lanes_out      = lane_reg;
    assign side_out.valid = vld_reg[4];
    assign side_out.tag   = tag_reg[4];
    assign side_out.coll  = coll5_reg;
    assign side_out.x2    = x2_reg[4];
    assign side_out.y2    = y2_reg[4];

endmodule

>>> src/cfp_div.sv
module cfp_div
    import cfp_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  cfp_side_t                 side_in,
    input  cfp_lane_t [1:0]           lanes_in,
    output cfp_side_t                 side_out,
    output logic [1:0][Q_W-1:0]       quo_out,
    output logic [1:0]                neg_out
);

    localparam int CMP_W = DEN_W + Q_W - 1;

    cfp_side_t side_reg [Q_W+1];

    assign side_reg[0] = side_in;

    // restoring division, one quotient bit per stage, top bit flags overflow
    for (genvar j = 0; j < Q_W; j++)
    begin : g_side
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                side_reg[j+1] <= '0;
            end
            else if (en)
            begin
                side_reg[j+1] <= side_reg[j];
            end
        end
    end

    for (genvar l = 0; l < 2; l++)
    begin : g_lane
        logic [NUM_W-1:0] rem_reg [Q_W+1];
        logic [DEN_W-1:0] den_reg [Q_W+1];
        logic [Q_W-1:0]   q_reg   [Q_W+1];
        logic             neg_reg [Q_W+1];

        assign rem_reg[0] = lanes_in[l].num;
        assign den_reg[0] = lanes_in[l].den;
        assign q_reg[0]   = '0;
        assign neg_reg[0] = lanes_in[l].neg;

        for (genvar j = 0; j < Q_W; j++)
        begin : g_stage
            localparam int K = Q_W - 1 - j;
            logic [CMP_W-1:0] sh;
            logic [CMP_W-1:0] diff;
            logic             ge;

            always_comb
            begin
                sh   = CMP_W'(den_reg[j]) << K;
                ge   = CMP_W'(rem_reg[j]) >= sh;
                diff = CMP_W'(rem_reg[j]) - sh;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[j+1] <= ge ? diff[NUM_W-1:0] : rem_reg[j];
                    den_reg[j+1] <= den_reg[j];
                    q_reg[j+1]   <= {q_reg[j][Q_W-2:0], ge};
                    neg_reg[j+1] <= neg_reg[j];
                end
            end
        end

        assign quo_out[l] = q_reg[Q_W];
        assign neg_out[l] = neg_reg[Q_W];
    end

    assign side_out = side_reg[Q_W];

endmodule

>>> src/cfp_sqrt.sv
module cfp_sqrt
    import cfp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  cfp_post_t         post_in,
    input  logic [SQ_W-1:0]   sq_in,
    output cfp_post_t         post_out,
    output logic [ROOT_W-1:0] root_out,
    output logic [SQ_W-1:0]   rem_out
);

    localparam int T_W = 2 * ROOT_W + 1;

    cfp_post_t         post_reg [ROOT_W+1];
    logic [SQ_W-1:0]   rem_reg  [ROOT_W+1];
    logic [ROOT_W-1:0] r_reg    [ROOT_W+1];

    assign post_reg[0] = post_in;
    assign rem_reg[0]  = sq_in;
    assign r_reg[0]    = '0;

    // one root bit per stage; remainder stays s - r^2
    for (genvar j = 0; j < ROOT_W; j++)
    begin : g_stage
        localparam int I = ROOT_W - 1 - j;
        logic [T_W-1:0] trial;
        logic [T_W-1:0] diff;
        logic           ge;

        always_comb
        begin
            trial = (T_W'(r_reg[j]) << (I + 1)) + (T_W'(1) << (2 * I));
            ge    = T_W'(rem_reg[j]) >= trial;
            diff  = T_W'(rem_reg[j]) - trial;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                post_reg[j+1] <= '0;
            end
            else if (en)
            begin
                post_reg[j+1] <= post_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j+1] <= ge ? diff[SQ_W-1:0] : rem_reg[j];
                r_reg[j+1]   <= ge ? (r_reg[j] | (ROOT_W'(1) << I)) : r_reg[j];
            end
        end
    end

    assign post_out = post_reg[ROOT_W];
    assign root_out = r_reg[ROOT_W];
    assign rem_out  = rem_reg[ROOT_W];

endmodule

>>> src/circle_from_three_points.sv
// Channel   Dir  Signals                         Contents
// s_axis    in   s_tvalid s_tready s_tdata[111:0] three points and tag
// m_axis    out  m_tvalid m_tready m_tdata[87:0]  center, radius, tag
//                m_tuser[1:0]                     status
// cfg       in   cfg_valid cfg_ready cfg_data     min_abs_det
//
// One transaction per cycle in and out while m_tready does not stall; the
// pipeline is dominated by the 27-stage restoring divider and the 25-stage square root.
// Reset clears all valid bits and loads min_abs_det with 1.
// A stall on m_tready freezes every stage together and drops s_tready.
module circle_from_three_points
    import cfp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // first_x, first_y, second_x, second_y, third_x, third_y, tag
    input  logic [111:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // center_x, center_y, radius, tag_echo
    output logic [87:0]  m_tdata,
    // status
    output logic [1:0]   m_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [15:0]  cfg_data
);

    logic            en;
    logic [CFG_W-1:0] min_det_reg;

    cfp_side_t       fr_side, dv_side;
    cfp_lane_t [1:0] fr_lanes;
    logic [1:0][Q_W-1:0] dv_quo;
    logic [1:0]      dv_neg;

    assign en        = !m_tvalid || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_det_reg <= CFG_W'(1);
        end
        else if (cfg_valid)
        begin
            min_det_reg <= cfg_data;
        end
    end

    cfp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (s_tvalid),
        .x1          (s_tdata[15:0]),
        .y1          (s_tdata[31:16]),
        .x2          (s_tdata[47:32]),
        .y2          (s_tdata[63:48]),
        .x3          (s_tdata[79:64]),
        .y3          (s_tdata[95:80]),
        .tag         (s_tdata[111:96]),
        .min_abs_det (min_det_reg),
        .side_out    (fr_side),
        .lanes_out   (fr_lanes)
    );

    cfp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .side_in  (fr_side),
        .lanes_in (fr_lanes),
        .side_out (dv_side),
        .quo_out  (dv_quo),
        .neg_out  (dv_neg)
    );

    // post stage 1: signed center and offset from the second point
    logic                c1_vld_reg;
    logic [TAG_W-1:0]    c1_tag_reg;
    logic                c1_coll_reg;
    logic [1:0]          c1_big_reg;
    logic [1:0]          c1_neg_reg;
    logic signed [27:0]  c1_c_reg  [2];
    logic signed [28:0]  c1_d_reg  [2];
    // post stage 2: magnitudes and center saturation
    logic                c2_vld_reg;
    logic [TAG_W-1:0]    c2_tag_reg;
    logic                c2_coll_reg;
    logic [1:0]          c2_ovf_reg;
    logic [1:0]          c2_csat_reg;
    logic [OUT_W-1:0]    c2_c_reg   [2];
    logic [23:0]         c2_a_reg   [2];
    // post stage 3: squares
    cfp_post_t           c3_post_reg;
    logic [47:0]         c3_sq_reg  [2];
    // post stage 4: sum
    cfp_post_t           c4_post_reg;
    logic [SQ_W-1:0]     c4_sum_reg;

    logic signed [27:0]  c1_c   [2];
    logic signed [15:0]  ref_pt [2];
    logic [28:0]         c2_abs [2];
    logic [OUT_W-1:0]    c2_c   [2];
    logic                c2_cs  [2];

    assign ref_pt[0] = dv_side.x2;
    assign ref_pt[1] = dv_side.y2;

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            c1_c[l] = dv_neg[l] ? -$signed({1'b0, dv_quo[l]}) : $signed({1'b0, dv_quo[l]});
            c2_abs[l] = c1_d_reg[l][28] ? 29'(-c1_d_reg[l]) : c1_d_reg[l];
            if (c1_big_reg[l])
            begin
                c2_c[l]  = c1_neg_reg[l] ? CTR_MIN : CTR_MAX;
                c2_cs[l] = 1'b1;
            end
            else if (c1_c_reg[l] > 28'sd8388607)
            begin
                c2_c[l]  = CTR_MAX;
                c2_cs[l] = 1'b1;
            end
            else if (c1_c_reg[l] < -28'sd8388608)
            begin
                c2_c[l]  = CTR_MIN;
                c2_cs[l] = 1'b1;
            end
            else
            begin
                c2_c[l]  = c1_c_reg[l][OUT_W-1:0];
                c2_cs[l] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_vld_reg  <= 1'b0;
            c2_vld_reg  <= 1'b0;
            c3_post_reg <= '0;
            c4_post_reg <= '0;
        end
        else if (en)
        begin
            c1_vld_reg        <= dv_side.valid;
            c2_vld_reg        <= c1_vld_reg;
            c3_post_reg.valid <= c2_vld_reg;
            c3_post_reg.tag   <= c2_tag_reg;
            c3_post_reg.coll  <= c2_coll_reg;
            c3_post_reg.sat   <= (|c2_csat_reg) | (|c2_ovf_reg);
            c3_post_reg.rad_ovf <= |c2_ovf_reg;
            c3_post_reg.cx    <= c2_c_reg[0];
            c3_post_reg.cy    <= c2_c_reg[1];
            c4_post_reg       <= c3_post_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c1_tag_reg  <= dv_side.tag;
            c1_coll_reg <= dv_side.coll;
            c2_tag_reg  <= c1_tag_reg;
            c2_coll_reg <= c1_coll_reg;
            for (int l = 0; l < 2; l++)
            begin
                c1_big_reg[l] <= dv_quo[l][Q_W-1];
                c1_neg_reg[l] <= dv_neg[l];
                c1_c_reg[l]   <= c1_c[l];
                c1_d_reg[l]   <= 29'(ref_pt[l]) - 29'(c1_c[l]);
                c2_ovf_reg[l] <= c1_big_reg[l] || (c2_abs[l] > 29'(RAD_MAX));
                c2_csat_reg[l] <= c2_cs[l];
                c2_c_reg[l]   <= c2_c[l];
                c2_a_reg[l]   <= c2_abs[l][23:0];
                c3_sq_reg[l]  <= c2_a_reg[l] * c2_a_reg[l];
            end
            c4_sum_reg <= {1'b0, c3_sq_reg[0]} + {1'b0, c3_sq_reg[1]};
        end
    end

    cfp_post_t         sq_post;
    logic [ROOT_W-1:0] sq_root;
    logic [SQ_W-1:0]   sq_rem;

    cfp_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .post_in  (c4_post_reg),
        .sq_in    (c4_sum_reg),
        .post_out (sq_post),
        .root_out (sq_root),
        .rem_out  (sq_rem)
    );

    // output register: round the root, apply collinear and saturation codes
    logic                out_vld_reg;
    logic [87:0]         out_data_reg;
    logic [STATUS_W-1:0] out_st_reg;

    logic [ROOT_W-1:0]   rnd;
    logic                rad_big;
    logic [OUT_W-1:0]    rad;
    logic [87:0]         data_next;
    logic [STATUS_W-1:0] st_next;

    always_comb
    begin
        rnd     = (sq_rem > SQ_W'(sq_root)) ? sq_root + ROOT_W'(1) : sq_root;
        rad_big = rnd[ROOT_W-1];
        rad     = (sq_post.rad_ovf || rad_big) ? RAD_MAX : rnd[OUT_W-1:0];
        if (sq_post.coll)
        begin
            data_next = {sq_post.tag, 72'd0};
            st_next   = ST_COLL;
        end
        else
        begin
            data_next = {sq_post.tag, rad, sq_post.cy, sq_post.cx};
            st_next   = (sq_post.sat || rad_big) ? ST_SAT : ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= sq_post.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= data_next;
            out_st_reg   <= st_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_st_reg;

endmodule

>>> bench/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import cfp_pkg::*;

    localparam int LATENCY    = 62;
    localparam int WDOG_LIMIT = 20000;
    localparam int N_RANDOM   = 600;

    typedef struct packed {
        logic [15:0]        tag;
        logic [1:0]         status;
        logic [OUT_W-1:0]   radius;
        logic [OUT_W-1:0]   cy;
        logic [OUT_W-1:0]   cx;
    } circle_t;

    class circle_scoreboard;
        circle_t    pending[$];
        logic [15:0] det_floor;
        int         errors;

        function new();
            det_floor = 16'd1;
            errors = 0;
        endfunction

        function longint unsigned root_round(longint unsigned s);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > s)
                b >>= 2;
            while (b != 0)
            begin
                if (s >= r + b)
                begin
                    s -= r + b;
                    r = (r >> 1) + b;
                end
                else
                    r >>= 1;
                b >>= 2;
            end
            if (s > r)
                r++;
            return r;
        endfunction

        // |num| / (2*|den|) + 1/4, truncated, then given the sign of num/den
        function longint div_round(longint num, longint den);
            longint unsigned a;
            longint unsigned d;
            longint unsigned q;
            a = num < 0 ? -num : num;
            d = den < 0 ? -den : den;
            q = (2 * a + d) / (4 * d);
            return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
        endfunction

        function void note_points(logic [111:0] pts);
            longint x1, y1, x2, y2, x3, y3, bc, cd, det, nx, ny, cx, cy, dx, dy;
            longint unsigned ad;
            longint unsigned rad;
            logic sat;
            circle_t c;
            x1 = $signed(pts[15:0]);   y1 = $signed(pts[31:16]);
            x2 = $signed(pts[47:32]);  y2 = $signed(pts[63:48]);
            x3 = $signed(pts[79:64]);  y3 = $signed(pts[95:80]);
            c = '0;
            c.tag = pts[111:96];
            bc = x1 * x1 + y1 * y1 - x2 * x2 - y2 * y2;
            cd = x2 * x2 + y2 * y2 - x3 * x3 - y3 * y3;
            det = (x1 - x2) * (y2 - y3) - (x2 - x3) * (y1 - y2);
            ad = det < 0 ? -det : det;
            if (det == 0 || ad < det_floor)
            begin
                c.status = ST_COLL;
                pending.insert(pending.size(), c);
                return;
            end
            sat = 1'b0;
            nx = bc * (y2 - y3) - cd * (y1 - y2);
            ny = cd * (x1 - x2) - bc * (x2 - x3);
            cx = div_round(nx, det);
            cy = div_round(ny, det);
            dx = x2 - cx;
            dy = y2 - cy;
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            if (dx > 64'hFFFFFF || dy > 64'hFFFFFF)
            begin
                rad = 64'hFFFFFF;
                sat = 1'b1;
            end
            else
            begin
                rad = root_round(dx * dx + dy * dy);
                if (rad > 64'hFFFFFF)
                begin
                    rad = 64'hFFFFFF;
                    sat = 1'b1;
                end
            end
            if (cx > 8388607)   begin cx = 8388607;  sat = 1'b1; end
            if (cx < -8388608)  begin cx = -8388608; sat = 1'b1; end
            if (cy > 8388607)   begin cy = 8388607;  sat = 1'b1; end
            if (cy < -8388608)  begin cy = -8388608; sat = 1'b1; end
            c.cx = cx[23:0];
            c.cy = cy[23:0];
            c.radius = rad[23:0];
            c.status = sat ? ST_SAT : ST_OK;
            pending.insert(pending.size(), c);
        endfunction

        function void check_circle(logic [87:0] data, logic [1:0] status);
            circle_t exp_c;
            circle_t got;
            got = {data[87:72], status, data[71:48], data[47:24], data[23:0]};
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result %h", got);
                return;
            end
            exp_c = pending.pop_front();
            if (got !== exp_c)
            begin
                errors++;
                if (errors <= 10)
                    $display({"mismatch: exp cx=%h cy=%h r=%h st=%0d tag=%h;",
                        " got cx=%h cy=%h r=%h st=%0d tag=%h"},
                        exp_c.cx, exp_c.cy, exp_c.radius, exp_c.status, exp_c.tag,
                        got.cx, got.cy, got.radius, got.status, got.tag);
            end
        endfunction
    endclass

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [111:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [87:0]  m_tdata;
    logic [1:0]   m_tuser;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [15:0]  cfg_data = '0;

    circle_scoreboard board = new();
    bit  hold_sink = 1'b0;
    bit  long_hold = 1'b0;
    int  idle_cycles = 0;

    always #10 clk = ~clk;

    circle_from_three_points dut (.*);

    function int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 40) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // valid stays high into the next transaction when there is no gap
    task automatic send_points(logic [111:0] pts);
        int g;
        g = hold_sink ? 0 : gap_len();
        if (g != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pts;
        do @(posedge clk); while (!s_tready);
        board.note_points(pts);
    endtask

    task automatic write_det_floor(logic [15:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        board.det_floor = v;
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    function logic [111:0] pack_pts(int x1, int y1, int x2, int y2, int x3, int y3);
        logic [15:0] t;
        t = 16'($urandom);
        return {t, y3[15:0], x3[15:0], y2[15:0], x2[15:0], y1[15:0], x1[15:0]};
    endfunction

    function logic [15:0] rnd_coord(int spread);
        if (spread == 0)
            return 16'($urandom);
        return 16'(int'($urandom_range(0, 2 * spread)) - spread);
    endfunction

    function logic [111:0] rnd_points();
        int p;
        int cx, cy, spread;
        logic [111:0] v;
        p = $urandom_range(0, 99);
        if (p < 10)
            return 112'({$urandom, $urandom, $urandom, $urandom});
        if (p < 20)
        begin
            // nearly collinear: all three points within 15 of the first, so det stays small
            cx = $signed(rnd_coord(2000));
            cy = $signed(rnd_coord(2000));
            spread = int'($urandom_range(0, 6)) - 3;
            return pack_pts(cx, cy, cx + 3 * spread, cy + 5 * spread,
                cx - 2 * spread, cy - 4 * spread + int'($urandom_range(0, 1)));
        end
        spread = (p < 60) ? 200 : (p < 85) ? 4000 : 0;
        v[111:96] = 16'($urandom);
        for (int i = 0; i < 6; i++)
            v[16*i +: 16] = rnd_coord(spread);
        return v;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.check_circle(m_tdata, m_tuser);
    end

    // output backpressure
    initial
    begin
        int g;
        @(posedge rst_n);
        forever
        begin
            if (long_hold)
            begin
                m_tready <= 1'b0;
                repeat (300) @(posedge clk);
                long_hold = 1'b0;
            end
            else if (hold_sink)
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                g = gap_len();
                if (g != 0)
                begin
                    m_tready <= 1'b0;
                    repeat (g) @(posedge clk);
                end
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        logic [15:0] floors [4];
        floors = '{16'd0, 16'd65535, 16'd300, 16'd1};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_points(pack_pts(0, 0, 16, 0, 0, 16));
        send_points(pack_pts(-32768, -32768, 32767, -32768, -32768, 32767));
        send_points(pack_pts(32767, 32767, -32768, 32767, 32767, -32768));
        send_points(pack_pts(5, 5, 5, 5, 5, 5));
        send_points(pack_pts(0, 0, 16, 16, 32, 32));
        send_points(pack_pts(0, 0, 1, 0, 0, 1));
        send_points(pack_pts(0, 0, 2, 1, 4, 3));
        send_points(pack_pts(-32768, 0, 32767, 0, 0, 1));
        send_points(pack_pts(-32768, -32768, 32767, 32767, -32767, -32768));
        send_points(pack_pts(100, -50, -100, 50, 3, 7));
        send_points(pack_pts(1, 1, -1, -1, 1, -1));
        send_points({16'hFFFF, {96{1'b1}}});
        send_points({16'h0000, 96'h0});
        send_points(pack_pts(-32768, 32767, 32767, -32768, 0, 0));
        drain();

        // fill the pipe while the output is held off
        long_hold = 1'b1;
        for (int i = 0; i < 120; i++)
            send_points(rnd_points());
        drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            write_det_floor(floors[ph]);
            send_points(pack_pts(0, 0, 1, 0, 0, 1));
            send_points(pack_pts(0, 0, 16, 0, 0, 16));
            hold_sink = (ph == 3);
            for (int i = 0; i < N_RANDOM / 4; i++)
            begin
                send_points(rnd_points());
                if (i == 100 && ph == 2)
                    drain();
            end
            hold_sink = 1'b0;
            drain();
        end

        if (board.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
